/* rtl/toy_cpu_with_rollback_defines.svh */
// Assertion macros shared by the register machine RTL.
`ifndef TOY_CPU_WITH_ROLLBACK_DEFINES_SVH
`define TOY_CPU_WITH_ROLLBACK_DEFINES_SVH

// Checked at every edge once reset has been released.
`define TCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define TCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tcr_pkg.sv */
// Package of codes and controller/datapath interface types for the register machine.
package tcr_pkg;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_ADDI  = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_SUBI  = 4'd3;
  localparam logic [3:0] OP_MOV   = 4'd4;
  localparam logic [3:0] OP_MOVI  = 4'd5;
  localparam logic [3:0] OP_LOAD  = 4'd6;
  localparam logic [3:0] OP_STORE = 4'd7;
  localparam logic [3:0] OP_START = 4'd8;
  localparam logic [3:0] OP_RB    = 4'd9;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ADDR    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  localparam logic [2:0] K_ALU   = 3'd0;
  localparam logic [2:0] K_LOAD  = 3'd1;
  localparam logic [2:0] K_STORE = 3'd2;
  localparam logic [2:0] K_START = 3'd3;
  localparam logic [2:0] K_RB    = 3'd4;
  localparam logic [2:0] K_ILL   = 3'd5;

  typedef struct packed {
    logic capture;
    logic rd_ops;
    logic rd_old;
    logic commit;
    logic clr_step;
    logic rb_read;
    logic rb_apply;
  } tcr_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       addr_ok;
    logic       rb_refuse;
    logic       rb_zero;
    logic       rb_done;
    logic       clr_done;
  } tcr_stat_t;

endpackage

/* rtl/tcr_datapath.sv */
// Datapath of the register machine: register file, data memory, undo log and result word.
`include "toy_cpu_with_rollback_defines.svh"

module tcr_datapath #(
  parameter int MEM_WORDS  = 256,
  parameter int NUM_REGS   = 8,
  parameter int UNDO_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  tcr_pkg::tcr_cmd_t  cmd,
  output tcr_pkg::tcr_stat_t stat,
  input  logic [3:0]         op,
  input  logic [2:0]         dest_reg,
  input  logic [2:0]         first_source,
  input  logic [2:0]         second_source,
  input  logic signed [31:0] immediate,
  input  logic signed [31:0] mem_address,
  input  logic [6:0]         rollback_steps,
  output logic [1:0]         status,
  output logic signed [31:0] data_value,
  output logic [31:0]        step_count,
  output logic               running
);
  import tcr_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int RW = $clog2(NUM_REGS);
  localparam int WW = (AW > RW) ? AW : RW;
  localparam int HW = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1;
  localparam int FW = $clog2(UNDO_DEPTH + 1);
  localparam int EW = 1 + WW + 32;

  // Register index folded into range by repeated subtraction.
  function automatic logic [RW-1:0] wrap_reg(input logic [2:0] idx);
    logic [2:0] v;
    v = idx;
    for (int i = 0; i < 3; i++) begin
      if (32'(v) >= NUM_REGS) v = v - 3'(NUM_REGS);
    end
    return RW'(v);
  endfunction

  // Latched instruction.
  logic [3:0]    op_q;
  logic [RW-1:0] rd_q;
  logic [RW-1:0] rs1_q;
  logic [RW-1:0] rs2_q;
  logic [31:0]   imm_q;
  logic [31:0]   addr_q;
  logic [6:0]    steps_q;

  // Architectural state.
  logic [31:0]         rf [NUM_REGS];
  logic [NUM_REGS-1:0] rf_valid;
  logic [31:0]         dmem [MEM_WORDS];
  logic [EW-1:0]       ulog [UNDO_DEPTH];
  logic [31:0]         step_cnt;
  logic                run;
  logic [HW-1:0]       head;
  logic [FW-1:0]       fill;

  // Working registers.
  logic [31:0]   rf_qa;
  logic [31:0]   rf_qb;
  logic [31:0]   mem_q;
  logic [EW-1:0] log_q;
  logic [31:0]   result_q;
  logic          refused_q;
  logic [6:0]    remaining;
  logic [AW-1:0] clr_addr;

  logic [2:0]    kind;
  logic          addr_ok;
  logic          refuse;
  logic          ok_write;
  logic          is_start;
  logic          is_rb_ok;
  logic [31:0]   alu;
  logic [31:0]   step_next;
  logic [1:0]    st;
  logic [HW-1:0] head_inc;
  logic [HW-1:0] head_dec;
  logic          log_is_mem;
  logic [WW-1:0] log_where;
  logic [31:0]   log_old;
  logic          rf_we;
  logic [RW-1:0] rf_wa;
  logic [31:0]   rf_wd;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic          push;
  logic [WW-1:0] push_where;
  logic [31:0]   push_old;
  logic          clr_last;

  always_comb begin
    case (op_q)
      OP_ADD, OP_ADDI, OP_SUB, OP_SUBI, OP_MOV, OP_MOVI: kind = K_ALU;
      OP_LOAD:  kind = K_LOAD;
      OP_STORE: kind = K_STORE;
      OP_START: kind = K_START;
      OP_RB:    kind = K_RB;
      default:  kind = K_ILL;
    endcase
  end

  assign addr_ok  = addr_q < 32'(MEM_WORDS);
  assign refuse   = (32'(steps_q) > 32'(fill)) || (32'(steps_q) > step_cnt);
  assign clr_last = clr_addr == AW'(MEM_WORDS - 1);

  assign stat.kind      = kind;
  assign stat.addr_ok   = addr_ok;
  assign stat.rb_refuse = refuse;
  assign stat.rb_zero   = steps_q == 7'd0;
  assign stat.rb_done   = remaining == 7'd0;
  assign stat.clr_done  = clr_last;

  always_comb begin
    case (op_q)
      OP_ADD:  alu = rf_qa + rf_qb;
      OP_ADDI: alu = rf_qa + imm_q;
      OP_SUB:  alu = rf_qa - rf_qb;
      OP_SUBI: alu = rf_qa - imm_q;
      OP_MOV:  alu = rf_qa;
      OP_MOVI: alu = imm_q;
      OP_LOAD: alu = mem_q;
      default: alu = rf_qa;
    endcase
  end

  assign ok_write = (kind == K_ALU) || ((kind == K_LOAD || kind == K_STORE) && addr_ok);
  assign is_start = kind == K_START;
  assign is_rb_ok = (kind == K_RB) && !refused_q;

  always_comb begin
    if (ok_write) begin
      step_next = step_cnt + 32'd1;
    end else if (is_start) begin
      step_next = 32'd0;
    end else if (is_rb_ok) begin
      step_next = step_cnt - 32'(steps_q);
    end else begin
      step_next = step_cnt;
    end
  end

  always_comb begin
    if (kind == K_ILL) begin
      st = ST_ILLEGAL;
    end else if ((kind == K_LOAD || kind == K_STORE) && !addr_ok) begin
      st = ST_ADDR;
    end else if (kind == K_RB && refused_q) begin
      st = ST_REFUSED;
    end else begin
      st = ST_OK;
    end
  end

  assign head_inc = (head == HW'(UNDO_DEPTH - 1)) ? HW'(0) : head + HW'(1);
  assign head_dec = (head == HW'(0)) ? HW'(UNDO_DEPTH - 1) : head - HW'(1);

  assign log_is_mem = log_q[EW-1];
  assign log_where  = log_q[EW-2:32];
  assign log_old    = log_q[31:0];

  assign push       = cmd.commit && ok_write;
  assign push_where = (kind == K_STORE) ? WW'(addr_q[AW-1:0]) : WW'(rd_q);
  assign push_old   = (kind == K_STORE) ? mem_q : rf_qb;

  assign rf_we = (push && kind != K_STORE) || (cmd.rb_apply && !log_is_mem);
  assign rf_wa = cmd.rb_apply ? log_where[RW-1:0] : rd_q;
  assign rf_wd = cmd.rb_apply ? log_old : result_q;

  assign mem_we = cmd.clr_step || (push && kind == K_STORE) || (cmd.rb_apply && log_is_mem);
  always_comb begin
    if (cmd.clr_step) begin
      mem_wa = clr_addr;
      mem_wd = 32'd0;
    end else if (cmd.rb_apply) begin
      mem_wa = log_where[AW-1:0];
      mem_wd = log_old;
    end else begin
      mem_wa = addr_q[AW-1:0];
      mem_wd = result_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      rd_q    <= wrap_reg(dest_reg);
      rs1_q   <= wrap_reg(first_source);
      rs2_q   <= wrap_reg(second_source);
      imm_q   <= immediate;
      addr_q  <= mem_address;
      steps_q <= rollback_steps;
    end
  end

  // Register file: two registered read ports, one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd_ops) begin
      rf_qa <= rf_valid[rs1_q] ? rf[rs1_q] : 32'd0;
      rf_qb <= rf_valid[rs2_q] ? rf[rs2_q] : 32'd0;
    end else if (cmd.rd_old) begin
      rf_qb <= rf_valid[rd_q] ? rf[rd_q] : 32'd0;
    end
    if (rf_we) rf[rf_wa] <= rf_wd;
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.commit && is_start)) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[rf_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_ops) mem_q <= dmem[addr_q[AW-1:0]];
    if (mem_we) dmem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.rb_read) log_q <= ulog[head_dec];
    if (push) ulog[head] <= {(kind == K_STORE), push_where, push_old};
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_old) result_q <= alu;
    if (cmd.rd_ops) begin
      refused_q <= refuse;
      remaining <= steps_q;
    end else if (cmd.rb_read) begin
      remaining <= remaining - 7'd1;
    end
    if (cmd.commit) begin
      status     <= st;
      data_value <= ok_write ? result_q : 32'd0;
      step_count <= step_next;
      running    <= is_start ? 1'b1 : run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= 32'd0;
      run      <= 1'b0;
      head     <= '0;
      fill     <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_last ? AW'(0) : clr_addr + AW'(1);
      if (cmd.rb_read) begin
        head <= head_dec;
        fill <= fill - FW'(1);
      end else if (cmd.commit) begin
        step_cnt <= step_next;
        if (is_start) begin
          run  <= 1'b1;
          head <= '0;
          fill <= '0;
        end else if (push) begin
          head <= head_inc;
          if (fill != FW'(UNDO_DEPTH)) fill <= fill + FW'(1);
        end
      end
    end
  end

  `TCR_ASSERT(a_rb_fill, cmd.rb_read |-> fill != '0, "rollback read with an empty log")
  `TCR_ASSERT(a_start_clears, cmd.commit && is_start |=> fill == '0 && step_cnt == 32'd0 && run, "start did not clear the machine")

endmodule

/* rtl/tcr_ctrl.sv */
// Sequencing state machine of the register machine.
`include "toy_cpu_with_rollback_defines.svh"

module tcr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  output logic               res_valid,
  input  logic               res_stall,
  output tcr_pkg::tcr_cmd_t  cmd,
  input  tcr_pkg::tcr_stat_t stat
);
  import tcr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_OLD   = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_RB_RD = 3'd5;
  localparam logic [2:0] S_RB_AP = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       from_start;
  logic       from_start_next;
  logic       slot_free;

  assign cmd_stall = state != S_IDLE;
  assign slot_free = !res_valid || !res_stall;

  always_comb begin
    state_next      = state;
    from_start_next = from_start;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_ops = 1'b1;
        case (stat.kind)
          K_ALU: state_next = S_OLD;
          K_LOAD, K_STORE: state_next = stat.addr_ok ? S_OLD : S_FIN;
          K_START: begin
            from_start_next = 1'b1;
            state_next      = S_CLEAR;
          end
          K_RB: state_next = (stat.rb_refuse || stat.rb_zero) ? S_FIN : S_RB_RD;
          default: state_next = S_FIN;
        endcase
      end
      S_OLD: begin
        cmd.rd_old = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          from_start_next = 1'b0;
          state_next      = from_start ? S_FIN : S_IDLE;
        end
      end
      S_RB_RD: begin
        cmd.rb_read = 1'b1;
        state_next  = S_RB_AP;
      end
      S_RB_AP: begin
        cmd.rb_apply = 1'b1;
        state_next   = stat.rb_done ? S_FIN : S_RB_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      from_start <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      from_start <= from_start_next;
      if (cmd.commit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  `TCR_ASSERT_ALWAYS(a_reset_clears, rst |=> state == S_CLEAR, "reset did not start the clearing sweep")
  `TCR_ASSERT(a_accept_reads, cmd_valid && !cmd_stall |=> state == S_READ, "accepted word not decoded")
  `TCR_ASSERT(a_commit_shows, state == S_FIN && slot_free |=> res_valid && state == S_IDLE, "finished step did not raise a result")

endmodule

/* rtl/toy_cpu_with_rollback.sv */
// Top level of the register machine with an undo log.
// Usage notes:
// The command channel (cmd_valid, cmd_stall) carries one decoded instruction word:
// op, dest_reg, first_source, second_source, immediate, mem_address and
// rollback_steps. A word is taken at a rising edge where cmd_valid is high and
// cmd_stall is low. The result channel (res_valid, res_stall) returns exactly one
// word per instruction: status, data_value, step_count and running.
// Order of work: arithmetic, move, load and store pass through accept, operand
// read, old-value read and commit on the way to the result register, an order set
// by the registered read ports of the register file and the data memory. Illegal
// ops, out-of-range addresses and refused or zero-step rollbacks skip the old-value
// read. A rollback of N steps reads each undo entry from the log memory into a
// register and then writes it back, once per step. A start sweeps the data memory
// to zero one word per cycle before its commit.
// Reset clears the registers and log at once and then sweeps the data memory to
// zero, with cmd_stall high throughout.
// One result word may wait in the output register while the next command is
// accepted; if res_stall holds it there, the next instruction waits in its final
// cycle, so a result is never overwritten before it has been taken.
module toy_cpu_with_rollback #(
  parameter int MEM_WORDS  = 256,
  parameter int NUM_REGS   = 8,
  parameter int UNDO_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [3:0]         op,
  input  logic [2:0]         dest_reg,
  input  logic [2:0]         first_source,
  input  logic [2:0]         second_source,
  input  logic signed [31:0] immediate,
  input  logic signed [31:0] mem_address,
  input  logic [6:0]         rollback_steps,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [1:0]         status,
  output logic signed [31:0] data_value,
  output logic [31:0]        step_count,
  output logic               running
);
  import tcr_pkg::*;

  // Commands from the sequencer and status flags back from the datapath.
  tcr_cmd_t  cmd;
  tcr_stat_t stat;

  // The controller owns the handshakes and the order of work for each step.
  tcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds all architectural state and the result word.
  tcr_datapath #(
    .MEM_WORDS  (MEM_WORDS),
    .NUM_REGS   (NUM_REGS),
    .UNDO_DEPTH (UNDO_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op             (op),
    .dest_reg       (dest_reg),
    .first_source   (first_source),
    .second_source  (second_source),
    .immediate      (immediate),
    .mem_address    (mem_address),
    .rollback_steps (rollback_steps),
    .status         (status),
    .data_value     (data_value),
    .step_count     (step_count),
    .running        (running)
  );

endmodule
